FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define SEM_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SEM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants of the Sobel edge magnitude block.
// ----------------------------------------------------------------------------
`default_nettype none

package sem_pkg;

    localparam int DEF_MAX_WIDTH      = 1024;
    localparam int DEF_MAX_HEIGHT     = 4096;
    localparam int DEF_LUMA_FRAC_BITS = 8;

    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam int RESET_WIDTH  = 1024;
    localparam int RESET_HEIGHT = 1024;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // luma weights, Q0.16
    localparam logic [15:0] WEIGHT_R = 16'd19595;
    localparam logic [15:0] WEIGHT_G = 16'd38470;
    localparam logic [15:0] WEIGHT_B = 16'd7471;

    localparam int PIX_W       = 8;
    localparam int MAG_W       = 8;
    localparam int ROOT_SQ_W   = 18;   // (2*255+1)^2 fits
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic is_pixel;   // carries a new luma sample
        logic row0;       // first row of the frame
        logic row_ge2;    // row index two or more
        logic col_zero;   // first column
        logic emit;       // produces a result
        logic last;       // final result of the frame
    } sem_ctl_t;

    localparam int CTL_W = $bits(sem_ctl_t);

    typedef struct packed {
        logic full;
        logic empty;
    } sem_qstat_t;

endpackage

`default_nettype wire

FILE: rtl/sobel_edge_magnitude.sv
// Path: a result comes from the request that completes its 3x3 window (one row plus
//   one pixel after its own pixel), via queue, stages B-E, root stages, result register.
// Throughput: one request per cycle while in_stall is low, set by the one read port
//   of each line store and the fully pipelined square root; output stalls freeze the back end.
// Reset: position counters, queue and pipeline valids clear; frame size
//   returns to 1024x1024. Line stores are not cleared.
// ----------------------------------------------------------------------------
// sobel_edge_magnitude
// Streamed RGB to luma, 3x3 Sobel gradient, rounded magnitude clipped to 255.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sobel_edge_magnitude #(
    parameter int MAX_WIDTH      = sem_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT     = sem_pkg::DEF_MAX_HEIGHT,
    parameter int LUMA_FRAC_BITS = sem_pkg::DEF_LUMA_FRAC_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration writes: frame width, frame height
    input  wire logic                              cfg_write,
    input  wire logic [sem_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [sem_pkg::CFG_DATA_W-1:0]    cfg_data,
    // pixel / drain requests
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              operation,
    input  wire logic [sem_pkg::PIX_W-1:0]         red,
    input  wire logic [sem_pkg::PIX_W-1:0]         green,
    input  wire logic [sem_pkg::PIX_W-1:0]         blue,
    // results
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic      [sem_pkg::MAG_W-1:0]         magnitude,
    output logic                                   frame_end
);

    // Queue entry: control flags, column, luma sample (Q8.F).
    localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int LUMA_W  = sem_pkg::PIX_W + LUMA_FRAC_BITS;
    localparam int ENTRY_W = sem_pkg::CTL_W + COL_W + LUMA_W;

    logic                 push;
    logic [ENTRY_W-1:0]   push_data;
    logic                 pop;
    logic [ENTRY_W-1:0]   head;
    sem_pkg::sem_qstat_t  q_stat;

    // Front: raster position, stray drain ticks dropped, luma computed,
    // each kept request tagged with what the back end must do with it.
    sem_front #(
        .MAX_WIDTH      (MAX_WIDTH),
        .MAX_HEIGHT     (MAX_HEIGHT),
        .LUMA_FRAC_BITS (LUMA_FRAC_BITS),
        .ENTRY_W        (ENTRY_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    // Decoupling queue: the front keeps taking requests while the back
    // end is held by a stalled result.
    sem_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (sem_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    // Back end: line stores, window, Sobel, squares, root pipeline, result.
    sem_back #(
        .MAX_WIDTH      (MAX_WIDTH),
        .LUMA_FRAC_BITS (LUMA_FRAC_BITS),
        .ENTRY_W        (ENTRY_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .magnitude (magnitude),
        .frame_end (frame_end)
    );

    // ---- checks ----
    `SEM_ASSERT_RST(a_no_push_full, clk, rst_n, push |-> !q_stat.full, "push into full queue")
    `SEM_ASSERT_RST(a_no_pop_empty, clk, rst_n, pop |-> !q_stat.empty, "pop from empty queue")
    `SEM_ASSERT_RST(a_qstat_sane, clk, rst_n, $onehot0({q_stat.full, q_stat.empty}), "queue full and empty")

endmodule

`default_nettype wire

FILE: rtl/sem_ram.sv
// ----------------------------------------------------------------------------
// sem_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 1024
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [DATA_W-1:0]                      wdata,
    input  wire logic                                   re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [DATA_W-1:0]                      rdata
);

    logic [DATA_W-1:0] mem_reg [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sem_queue.sv
// ----------------------------------------------------------------------------
// sem_queue
// Small FIFO between the classifying front and the filter back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = sem_pkg::QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [WIDTH-1:0]  push_data,
    input  wire logic              pop,
    output logic      [WIDTH-1:0]  head,
    output sem_pkg::sem_qstat_t    q_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign head         = slot_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sem_front.sv
// ----------------------------------------------------------------------------
// sem_front
// Accepts requests, tracks raster position, drops stray drain ticks,
// converts RGB to luma and classifies each kept request for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_front #(
    parameter int MAX_WIDTH      = sem_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT     = sem_pkg::DEF_MAX_HEIGHT,
    parameter int LUMA_FRAC_BITS = sem_pkg::DEF_LUMA_FRAC_BITS,
    parameter int ENTRY_W        = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [sem_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [sem_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              operation,
    input  wire logic [sem_pkg::PIX_W-1:0]         red,
    input  wire logic [sem_pkg::PIX_W-1:0]         green,
    input  wire logic [sem_pkg::PIX_W-1:0]         blue,
    input  wire sem_pkg::sem_qstat_t               q_stat,
    output logic                                   push,
    output logic      [ENTRY_W-1:0]                push_data
);

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WE_W   = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
    localparam int LUMA_W = sem_pkg::PIX_W + LUMA_FRAC_BITS;
    localparam int SUM_W  = 25;
    localparam int SHIFT  = 16 - LUMA_FRAC_BITS;
    localparam int HALF   = 1 << (15 - LUMA_FRAC_BITS);
    localparam int RST_W_EFF = (sem_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH
                                                                  : sem_pkg::RESET_WIDTH;
    localparam int RST_H_EFF = (sem_pkg::RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT
                                                                    : sem_pkg::RESET_HEIGHT;

    logic [WE_W-1:0]   width_reg;
    logic [ROW_W-1:0]  height_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;

    logic [31:0]       w_raw;
    logic [31:0]       h_raw;
    logic [31:0]       w_clamp;
    logic [31:0]       h_clamp;
    logic              accept;
    logic              pixel_row;
    logic              keep;
    logic              col_wrap;
    logic [SUM_W-1:0]  luma_sum;
    logic [LUMA_W-1:0] luma;
    sem_pkg::sem_ctl_t ctl;

    assign in_stall = q_stat.full;
    assign accept   = in_valid && !in_stall;

    // register clamp: zero acts as one, above maximum acts as maximum
    assign w_raw   = 32'(cfg_data[sem_pkg::CFG_WIDTH_W-1:0]);
    assign h_raw   = 32'(cfg_data[sem_pkg::CFG_HEIGHT_W-1:0]);
    assign w_clamp = (w_raw == 32'd0) ? 32'd1 :
                     (w_raw > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : w_raw;
    assign h_clamp = (h_raw == 32'd0) ? 32'd1 :
                     (h_raw > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : h_raw;

    assign luma_sum = SUM_W'(sem_pkg::WEIGHT_R) * SUM_W'(red)
                    + SUM_W'(sem_pkg::WEIGHT_G) * SUM_W'(green)
                    + SUM_W'(sem_pkg::WEIGHT_B) * SUM_W'(blue)
                    + SUM_W'(HALF);
    assign luma     = luma_sum[SHIFT +: LUMA_W];

    // rows past the height are drain rows; any request there is a drain tick
    assign pixel_row = (row_reg < height_reg);
    assign keep      = !(pixel_row && (operation == sem_pkg::OP_DRAIN));

    assign ctl.is_pixel = pixel_row;
    assign ctl.row0     = (row_reg == '0);
    assign ctl.row_ge2  = (row_reg >= ROW_W'(2));
    assign ctl.col_zero = (col_reg == '0);
    assign ctl.emit     = ctl.col_zero ? ctl.row_ge2 : (row_reg != '0);
    assign ctl.last     = (row_reg == height_reg + ROW_W'(1));

    assign col_wrap  = (32'(col_reg) + 32'd1 >= 32'(width_reg));
    assign push      = accept && keep;
    assign push_data = {ctl, col_reg, luma};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WE_W'(RST_W_EFF);
            height_reg <= ROW_W'(RST_H_EFF);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (cfg_write)
        begin
            // any write restarts the frame
            case (cfg_index)
                sem_pkg::REG_FRAME_WIDTH:  width_reg  <= WE_W'(w_clamp);
                sem_pkg::REG_FRAME_HEIGHT: height_reg <= ROW_W'(h_clamp);
                default: ;
            endcase
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (push)
        begin
            if (ctl.last)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (col_wrap)
            begin
                col_reg <= '0;
                row_reg <= row_reg + ROW_W'(1);
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sem_back.sv
// ----------------------------------------------------------------------------
// sem_back
// Line stores, 3x3 window, Sobel sums, squares and an 8-stage pipelined
// square root, ending in the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_back #(
    parameter int MAX_WIDTH      = sem_pkg::DEF_MAX_WIDTH,
    parameter int LUMA_FRAC_BITS = sem_pkg::DEF_LUMA_FRAC_BITS,
    parameter int ENTRY_W        = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire sem_pkg::sem_qstat_t           q_stat,
    input  wire logic [ENTRY_W-1:0]            head,
    output logic                               pop,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [sem_pkg::MAG_W-1:0]     magnitude,
    output logic                               frame_end
);

    localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int LUMA_W  = sem_pkg::PIX_W + LUMA_FRAC_BITS;
    localparam int GW      = LUMA_W + 3;
    localparam int AW      = LUMA_W + 2;
    localparam int SQ_W    = 2 * AW;
    localparam int S_W     = SQ_W + 1;
    localparam int SHIFT   = 2 * LUMA_FRAC_BITS - 2;
    localparam int RQ_W    = sem_pkg::ROOT_SQ_W;
    localparam int MW      = sem_pkg::MAG_W;
    localparam logic [S_W-1:0] RQ_MAX = S_W'((1 << RQ_W) - 1);

    function automatic logic signed [GW-1:0] sx(input logic [LUMA_W-1:0] v);
        sx = $signed({3'b000, v});
    endfunction

    logic advance;

    // ---- queue head ----
    sem_pkg::sem_ctl_t  h_ctl;
    logic [COL_W-1:0]   h_col;

    assign h_ctl   = sem_pkg::sem_ctl_t'(head[ENTRY_W-1 -: sem_pkg::CTL_W]);
    assign h_col   = head[LUMA_W +: COL_W];
    assign advance = !out_valid || !out_stall;
    assign pop     = advance && !q_stat.empty;

    // ---- stage B: line store read data ----
    logic               b_valid_reg;
    sem_pkg::sem_ctl_t  b_ctl_reg;
    logic [COL_W-1:0]   b_col_reg;
    logic [LUMA_W-1:0]  b_luma_reg;
    logic [LUMA_W-1:0]  up_rd;
    logic [LUMA_W-1:0]  mid_rd;
    logic [LUMA_W-1:0]  up_eff;
    logic [LUMA_W-1:0]  mid_eff;
    logic               up_we;
    logic               mid_we;

    logic               prev_up_we_reg;
    logic               prev_mid_we_reg;
    logic [COL_W-1:0]   prev_col_reg;
    logic [LUMA_W-1:0]  prev_up_reg;
    logic [LUMA_W-1:0]  prev_mid_reg;

    logic [LUMA_W-1:0]  col_v [0:2];
    logic [LUMA_W-1:0]  mtap_reg [0:2];
    logic [LUMA_W-1:0]  rtap_reg [0:2];

    assign up_we  = advance && b_valid_reg && b_ctl_reg.is_pixel && !b_ctl_reg.row0;
    assign mid_we = advance && b_valid_reg && b_ctl_reg.is_pixel;

    sem_ram #(.DATA_W(LUMA_W), .DEPTH(MAX_WIDTH)) u_upper (
        .clk   (clk),
        .we    (up_we),
        .waddr (b_col_reg),
        .wdata (mid_eff),
        .re    (pop),
        .raddr (h_col),
        .rdata (up_rd)
    );

    sem_ram #(.DATA_W(LUMA_W), .DEPTH(MAX_WIDTH)) u_middle (
        .clk   (clk),
        .we    (mid_we),
        .waddr (b_col_reg),
        .wdata (b_luma_reg),
        .re    (pop),
        .raddr (h_col),
        .rdata (mid_rd)
    );

    // the read of the next request shares an edge with this write: forward it
    assign up_eff  = (prev_up_we_reg && prev_col_reg == b_col_reg) ? prev_up_reg : up_rd;
    assign mid_eff = (prev_mid_we_reg && prev_col_reg == b_col_reg) ? prev_mid_reg : mid_rd;

    // column of three luma values, rows clamped at the frame edges
    always_comb
    begin
        if (b_ctl_reg.is_pixel && b_ctl_reg.row0)
        begin
            col_v[0] = b_luma_reg;
            col_v[1] = b_luma_reg;
            col_v[2] = b_luma_reg;
        end
        else
        begin
            col_v[1] = mid_eff;
            col_v[0] = b_ctl_reg.row_ge2 ? up_eff : mid_eff;
            col_v[2] = b_ctl_reg.is_pixel ? b_luma_reg : mid_eff;
        end
    end

    // ---- stage C: window columns ----
    logic               c_emit_reg;
    logic               c_last_reg;
    logic [LUMA_W-1:0]  lw_reg [0:2];
    logic [LUMA_W-1:0]  cw_reg [0:2];
    logic [LUMA_W-1:0]  rw_reg [0:2];
    logic signed [GW-1:0] gx;
    logic signed [GW-1:0] gy;

    assign gx = sx(rw_reg[0]) + (sx(rw_reg[1]) <<< 1) + sx(rw_reg[2])
              - sx(lw_reg[0]) - (sx(lw_reg[1]) <<< 1) - sx(lw_reg[2]);
    assign gy = sx(lw_reg[2]) + (sx(cw_reg[2]) <<< 1) + sx(rw_reg[2])
              - sx(lw_reg[0]) - (sx(cw_reg[0]) <<< 1) - sx(rw_reg[0]);

    // ---- stage D: gradients ----
    logic               d_emit_reg;
    logic               d_last_reg;
    logic signed [GW-1:0] gx_reg;
    logic signed [GW-1:0] gy_reg;
    logic [GW-1:0]      gx_neg;
    logic [GW-1:0]      gy_neg;
    logic [AW-1:0]      ax;
    logic [AW-1:0]      ay;
    logic [SQ_W-1:0]    sqx;
    logic [SQ_W-1:0]    sqy;

    assign gx_neg = -gx_reg;
    assign gy_neg = -gy_reg;
    assign ax     = gx_reg[GW-1] ? gx_neg[AW-1:0] : gx_reg[AW-1:0];
    assign ay     = gy_reg[GW-1] ? gy_neg[AW-1:0] : gy_reg[AW-1:0];
    assign sqx    = ax * ax;
    assign sqy    = ay * ay;

    // ---- stage E: squares ----
    logic               e_emit_reg;
    logic               e_last_reg;
    logic [SQ_W-1:0]    sqx_reg;
    logic [SQ_W-1:0]    sqy_reg;
    logic [S_W-1:0]     ssum;
    logic [S_W-1:0]     qs;
    logic [RQ_W-1:0]    qc;

    // (2m-1)^2 * 2^(2F) <= 4s  <=>  (2m-1)^2 <= floor(s / 2^(2F-2))
    assign ssum = S_W'(sqx_reg) + S_W'(sqy_reg);
    assign qs   = ssum >> SHIFT;
    assign qc   = (qs > RQ_MAX) ? '1 : qs[RQ_W-1:0];

    // ---- root stages: a load stage, then one result bit per stage, MSB first ----
    logic               r_emit_reg [0:MW];
    logic               r_last_reg [0:MW];
    logic [RQ_W-1:0]    r_q_reg    [0:MW];
    logic [MW-1:0]      r_m_reg    [0:MW];

    for (genvar k = 0; k <= MW; k++)
    begin : g_root
        if (k == 0)
        begin : g_load
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    r_emit_reg[k] <= 1'b0;
                end
                else if (advance)
                begin
                    r_emit_reg[k] <= e_emit_reg;
                end
            end

            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    r_last_reg[k] <= e_last_reg;
                    r_q_reg[k]    <= qc;
                    r_m_reg[k]    <= '0;
                end
            end
        end
        else
        begin : g_step
            logic [MW-1:0]   trial;
            logic [MW:0]     odd;
            logic [RQ_W-1:0] odd_sq;

            assign trial  = r_m_reg[k-1] | (MW'(1) << (MW - k));
            assign odd    = {trial, 1'b0} - (MW+1)'(1);
            assign odd_sq = odd * odd;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    r_emit_reg[k] <= 1'b0;
                end
                else if (advance)
                begin
                    r_emit_reg[k] <= r_emit_reg[k-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    r_last_reg[k] <= r_last_reg[k-1];
                    r_q_reg[k]    <= r_q_reg[k-1];
                    r_m_reg[k]    <= (odd_sq <= r_q_reg[k-1]) ? trial : r_m_reg[k-1];
                end
            end
        end
    end

    // ---- result register ----
    logic               out_valid_reg;
    logic [MW-1:0]      mag_reg;
    logic               fe_reg;

    assign out_valid = out_valid_reg;
    assign magnitude = mag_reg;
    assign frame_end = fe_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg     <= 1'b0;
            prev_up_we_reg  <= 1'b0;
            prev_mid_we_reg <= 1'b0;
            c_emit_reg      <= 1'b0;
            d_emit_reg      <= 1'b0;
            e_emit_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else if (advance)
        begin
            b_valid_reg     <= pop;
            prev_up_we_reg  <= up_we;
            prev_mid_we_reg <= mid_we;
            c_emit_reg      <= b_valid_reg && b_ctl_reg.emit;
            d_emit_reg      <= c_emit_reg;
            e_emit_reg      <= d_emit_reg;
            out_valid_reg   <= r_emit_reg[MW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_ctl_reg    <= h_ctl;
            b_col_reg    <= h_col;
            b_luma_reg   <= head[LUMA_W-1:0];
            prev_col_reg <= b_col_reg;
            prev_up_reg  <= mid_eff;
            prev_mid_reg <= b_luma_reg;

            if (b_valid_reg)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    lw_reg[i] <= mtap_reg[i];
                    cw_reg[i] <= rtap_reg[i];
                    // right edge: the last column repeats
                    rw_reg[i] <= b_ctl_reg.col_zero ? rtap_reg[i] : col_v[i];
                    mtap_reg[i] <= b_ctl_reg.col_zero ? col_v[i] : rtap_reg[i];
                    rtap_reg[i] <= col_v[i];
                end
            end
            c_last_reg <= b_ctl_reg.last;
            gx_reg     <= gx;
            gy_reg     <= gy;
            d_last_reg <= c_last_reg;
            sqx_reg    <= sqx;
            sqy_reg    <= sqy;
            e_last_reg <= d_last_reg;
            mag_reg    <= r_m_reg[MW];
            fe_reg     <= r_last_reg[MW];
        end
    end

endmodule

`default_nettype wire
